// ----- src/modular_exponentiation_assert.svh -----
// Assertion macros for the block's top module.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MODEXP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/modexp_pkg.sv -----
package modexp_pkg;

    // Width of every payload field at the ports.
    localparam int FIELD_BITS = 64;

    // Handshake between the sequencer and the shared multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_BIT,
        S_MUL,
        S_SQR,
        S_DONE
    } state_t;

endpackage

// ----- src/modular_exponentiation.sv -----
// Sequence, input transaction to out_valid: the shared unit reduces the base mod m, then walks
// the exponent LSB first, multiplying the result by the square for each set bit and squaring
// for every bit but the last; then the output is loaded. A zero modulus skips to the output load.
// Throughput: one transaction at a time; the shared mod-multiplier, one bit per cycle, sets it.
// Reset: rst_n, asynchronous, active low; clears the sequencer and the output valid flag.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
    parameter int OPERAND_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [modexp_pkg::FIELD_BITS-1:0]  base_value,
    input  logic [modexp_pkg::FIELD_BITS-1:0]  exponent_value,
    input  logic [modexp_pkg::FIELD_BITS-1:0]  modulus_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [modexp_pkg::FIELD_BITS-1:0]  power_result,
    output logic                               zero_modulus_error
);
    import modexp_pkg::*;

    localparam int W  = OPERAND_BITS;
    localparam int IW = $clog2(W);

    state_t        state_reg, state_next;

    // Running result, running square, exponent shifted right, modulus.
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic [W-1:0]  expo_reg, expo_next;
    logic [W-1:0]  m_reg, m_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          err_reg, err_next;

    // Output register: parts the result from the next transaction.
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] power_result_reg;
    logic                  zero_modulus_error_reg;

    logic          accept;
    logic          load_out;
    logic          last_bit;
    logic [W-1:0]  in_base;
    logic [W-1:0]  in_mod;

    // Shared multiplier.
    logic          unit_start;
    logic [W-1:0]  unit_a;
    logic [W-1:0]  unit_b;
    logic [W-1:0]  unit_result;
    mm_status_t    unit_status;

    // Only the low W bits of each field count.
    assign in_base  = base_value[W-1:0];
    assign in_mod   = modulus_value[W-1:0];
    assign accept   = in_valid && !in_stall;
    assign last_bit = (idx_reg == IW'(W - 1));

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .op_a   (unit_a),
        .op_b   (unit_b),
        .op_m   (m_reg),
        .result (unit_result),
        .status (unit_status)
    );

    // Next state: reduce the base, then walk the exponent LSB first.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (in_mod == '0) ? S_DONE : S_RED;
            end
            S_RED:
            begin
                if (unit_status.done)
                    state_next = S_BIT;
            end
            S_BIT:
            begin
                if (expo_reg[0])
                    state_next = S_MUL;
                else if (last_bit)
                    state_next = S_DONE;
                else
                    state_next = S_SQR;
            end
            S_MUL:
            begin
                // Skip the final squaring: it cannot reach the result.
                if (unit_status.done)
                    state_next = last_bit ? S_DONE : S_SQR;
            end
            S_SQR:
            begin
                if (unit_status.done)
                    state_next = S_BIT;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and the operands of the shared unit.
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        load_out   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
        unit_start = (state_reg inside {S_RED, S_MUL, S_SQR})
                     && !unit_status.busy && !unit_status.done;
        unit_a     = '0;
        unit_b     = '0;
        case (state_reg)
            S_RED:
            begin
                // 1 * base, scanned bit by bit, leaves base mod m.
                unit_a = W'(1);
                unit_b = sq_reg;
            end
            S_MUL:
            begin
                unit_a = acc_reg;
                unit_b = sq_reg;
            end
            S_SQR:
            begin
                unit_a = sq_reg;
                unit_b = sq_reg;
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        expo_next = expo_reg;
        m_next    = m_reg;
        idx_next  = idx_reg;
        err_next  = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // 1 mod m: zero when m is one; a zero modulus flags and gives 0.
                    acc_next  = (in_mod == W'(1) || in_mod == '0) ? '0 : W'(1);
                    sq_next   = in_base;
                    expo_next = exponent_value[W-1:0];
                    m_next    = in_mod;
                    idx_next  = '0;
                    err_next  = (in_mod == '0);
                end
            end
            S_RED:
            begin
                if (unit_status.done)
                    sq_next = unit_result;
            end
            S_MUL:
            begin
                if (unit_status.done)
                    acc_next = unit_result;
            end
            S_SQR:
            begin
                if (unit_status.done)
                begin
                    sq_next   = unit_result;
                    expo_next = expo_reg >> 1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Hold the result until taken; drop valid once it is.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        expo_reg <= expo_next;
        m_reg    <= m_next;
        err_reg  <= err_next;
        if (load_out)
        begin
            power_result_reg       <= FIELD_BITS'(acc_reg);
            zero_modulus_error_reg <= err_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign power_result       = power_result_reg;
    assign zero_modulus_error = zero_modulus_error_reg;

    // A flagged result always carries zero.
    `MODEXP_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid_reg && zero_modulus_error_reg, power_result_reg == '0, "zero modulus result is not zero")
    // The multiplier finishes only while the sequencer waits on it.
    `MODEXP_ASSERT_IMPL(a_done_in_op, clk, rst_n, unit_status.done, state_reg == S_RED || state_reg == S_MUL || state_reg == S_SQR, "multiplier done outside an operation")
    // An accepted transaction closes the input until its result is out.
    `MODEXP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, in_stall, "input open right after a transaction")
    // A start always leaves the shared unit busy and not yet done.
    `MODEXP_ASSERT_NEXT(a_start_runs, clk, rst_n, unit_start, unit_status.busy && !unit_status.done, "multiplier did not start")

endmodule

// ----- src/modexp_mulmod.sv -----
module modexp_mulmod #(
    parameter int W = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             op_a,
    input  logic [W-1:0]             op_b,
    input  logic [W-1:0]             op_m,
    output logic [W-1:0]             result,
    output modexp_pkg::mm_status_t   status
);
    import modexp_pkg::*;

    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  dbl;
    logic [W-1:0]  step;

    // (x + y) mod m for x, y below m; never overflows W bits.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W-1:0] gap;
        gap = m - y;
        if (x >= gap)
            return x - gap;
        return x + y;
    endfunction

    // One multiplier bit per cycle while busy: double, then add the multiplicand if the bit is set.
    always_comb
    begin
        dbl  = add_mod(acc_reg, acc_reg, m_reg);
        step = b_reg[W-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            m_next    = op_m;
            cnt_next  = CW'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign result      = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
